// ===== hdl/piq_pkg.sv =====
// Shared constants, types and the index tap table for the patch index and quantize block.
package piq_pkg;

  localparam int LEVELS        = 5;
  localparam int PATCH_SAMPLES = 64;
  localparam int PIX_W         = 8;
  localparam int POS_W         = $clog2(PATCH_SAMPLES);
  localparam int SUM_W         = 14;
  localparam int IDX_W         = 13;
  localparam int TAP_W         = $clog2(IDX_W);
  // Quotient bits needed to hold LEVELS itself before clamping.
  localparam int QBITS         = $clog2(LEVELS + 1);
  localparam int QB_W          = (QBITS > 1) ? $clog2(QBITS) : 1;
  localparam int LEVEL_SHIFT   = $clog2(PATCH_SAMPLES);

  // Tap slot that tests the center pixel instead of a stored patch pixel.
  localparam logic [TAP_W-1:0] CENTER_TAP = TAP_W'(6);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Patch positions tested for index bits 12 down to 0.
  localparam pos_t TAP_POS [IDX_W] = '{
    pos_t'(9),  pos_t'(14), pos_t'(19), pos_t'(20), pos_t'(26), pos_t'(29), pos_t'(0),
    pos_t'(34), pos_t'(37), pos_t'(43), pos_t'(44), pos_t'(49), pos_t'(54)
  };

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_IDX_RD  = 7'b0000010,
    S_IDX_CMP = 7'b0000100,
    S_Q_RD    = 7'b0001000,
    S_Q_MUL   = 7'b0010000,
    S_Q_DIV   = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_e;

  typedef struct packed {
    sum_t diff;
    logic borrow;
  } cs_res_t;

endpackage

// ===== hdl/piq_if.sv =====
// Valid/ready channel interfaces for patch samples in and quantized results out.
interface piq_in_if;
  import piq_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  pix_t sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink (input valid, input kind, input sample, output ready);
endinterface

interface piq_out_if;
  import piq_pkg::*;
  logic              valid;
  logic              ready;
  pix_t              value;
  pos_t              position;
  logic [IDX_W-1:0]  patch_index;
  logic              last;

  modport source (output valid, output value, output position, output patch_index,
                  output last, input ready);
  modport sink (input valid, input value, input position, input patch_index,
                input last, output ready);
endinterface

// ===== hdl/piq_cmpsub.sv =====
// Shared subtract and compare unit used for the mean tests and the level division.
module piq_cmpsub (
  input  piq_pkg::sum_t    a_i,
  input  piq_pkg::sum_t    b_i,
  output piq_pkg::cs_res_t res_o
);
  import piq_pkg::*;

  logic [SUM_W:0] full;

  assign full         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff   = full[SUM_W-1:0];
  assign res_o.borrow = full[SUM_W];

endmodule

// ===== hdl/patch_index_and_quantize.sv =====
// Top level: patch loader, 13-bit mean index and per-pixel level quantizer.
// Loading takes one cycle per request; center pixel requests are taken in the same way.
// After the 64th sample the index is built over 13 taps, each a memory read plus a compare.
// Each result is then read, scaled and, when quantized, divided one quotient bit per cycle
// through the shared subtractor; raw or flat results skip the division; output may stall.
// Reset clears the counters and accumulators, sets quantize_enable and leaves the store as is.
module patch_index_and_quantize (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  piq_in_if.sink    in_ch,
  piq_out_if.source out_ch
);
  import piq_pkg::*;

  state_e            state_q, state_d;
  pix_t              mem_q [PATCH_SAMPLES];
  pix_t              rdata_q;
  pos_t              rd_addr;
  pos_t              cnt_q;
  sum_t              sum_q;
  pix_t              min_q, max_q, center_q;
  logic              qen_q;
  logic [TAP_W-1:0]  tap_q;
  logic [IDX_W-1:0]  idx_q;
  pos_t              pos_q;
  sum_t              num_q;
  logic [QBITS-1:0]  quo_q, quo_d;
  logic [QB_W-1:0]   qbit_q;
  pix_t              value_q;
  pix_t              range;
  pix_t              pix_sel;
  sum_t              unit_a, unit_b;
  cs_res_t           unit_res;
  logic              in_fire, out_fire;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign range    = max_q - min_q;
  assign pix_sel  = (tap_q == CENTER_TAP) ? center_q : rdata_q;

  assign in_ch.ready        = (state_q == S_LOAD);
  assign out_ch.valid       = (state_q == S_OUT);
  assign out_ch.value       = value_q;
  assign out_ch.position    = pos_q;
  assign out_ch.patch_index = idx_q;
  assign out_ch.last        = (pos_q == pos_t'(PATCH_SAMPLES - 1));

  // The shared unit compares sum against 64*pixel, or trials the shifted range.
  always_comb begin
    if (state_q == S_IDX_CMP) begin
      unit_a = sum_q;
      unit_b = SUM_W'(pix_sel) << LEVEL_SHIFT;
    end else begin
      unit_a = num_q;
      unit_b = SUM_W'(range) << qbit_q;
    end
  end

  piq_cmpsub u_cmpsub (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .res_o(unit_res)
  );

  always_comb begin
    quo_d = quo_q;
    if (!unit_res.borrow) begin
      quo_d = quo_q | (QBITS'(1) << qbit_q);
    end
  end

  assign rd_addr = (state_q == S_IDX_RD) ? TAP_POS[tap_q] : pos_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_ch.kind) begin
      mem_q[cnt_q] <= in_ch.sample;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire && !in_ch.kind && cnt_q == pos_t'(PATCH_SAMPLES - 1)) begin
          state_d = S_IDX_RD;
        end
      end
      S_IDX_RD:  state_d = S_IDX_CMP;
      S_IDX_CMP: state_d = (tap_q == TAP_W'(IDX_W - 1)) ? S_Q_RD : S_IDX_RD;
      S_Q_RD:    state_d = S_Q_MUL;
      S_Q_MUL: begin
        if (!qen_q || max_q <= min_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_Q_DIV;
        end
      end
      S_Q_DIV:   state_d = (qbit_q == '0) ? S_OUT : S_Q_DIV;
      S_OUT: begin
        if (out_fire) begin
          state_d = out_ch.last ? S_LOAD : S_Q_RD;
        end
      end
      default:   state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      sum_q    <= '0;
      min_q    <= '1;
      max_q    <= '0;
      center_q <= '0;
      qen_q    <= 1'b1;
      tap_q    <= '0;
      pos_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        qen_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        if (in_ch.kind) begin
          center_q <= in_ch.sample;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          sum_q <= sum_q + SUM_W'(in_ch.sample);
          if (in_ch.sample < min_q) begin
            min_q <= in_ch.sample;
          end
          if (in_ch.sample > max_q) begin
            max_q <= in_ch.sample;
          end
          tap_q <= '0;
        end
      end
      if (state_q == S_IDX_CMP) begin
        tap_q <= tap_q + 1'b1;
        pos_q <= '0;
      end
      if (out_fire) begin
        pos_q <= pos_q + 1'b1;
        if (out_ch.last) begin
          sum_q <= '0;
          min_q <= '1;
          max_q <= '0;
        end
      end
    end
  end

  // Datapath registers of the index and the level division.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDX_RD && tap_q == '0) begin
      idx_q <= '0;
    end
    if (state_q == S_IDX_CMP) begin
      // Bit 12 is tested first, so the index shifts in from the bottom.
      idx_q <= {idx_q[IDX_W-2:0], unit_res.borrow};
    end
    if (state_q == S_Q_MUL) begin
      num_q   <= SUM_W'(rdata_q - min_q) * SUM_W'(LEVELS);
      quo_q   <= '0;
      qbit_q  <= QB_W'(QBITS - 1);
      value_q <= qen_q ? '0 : rdata_q;
    end
    if (state_q == S_Q_DIV) begin
      quo_q  <= quo_d;
      qbit_q <= qbit_q - 1'b1;
      if (!unit_res.borrow) begin
        num_q <= unit_res.diff;
      end
      if (qbit_q == '0) begin
        if (quo_d > QBITS'(LEVELS - 1)) begin
          value_q <= PIX_W'(LEVELS - 1);
        end else begin
          value_q <= PIX_W'(quo_d);
        end
      end
    end
  end

endmodule
